// File: sv/dqd_pkg.sv
// shared types, constants and sizes for the double-ended queue with delete
package dqd_pkg;

   localparam int DEPTH         = 16;
   localparam int VALUE_BITS    = 32;
   localparam int IDX_BITS      = $clog2(DEPTH);
   localparam int CNT_BITS      = $clog2(DEPTH + 1);
   localparam int OUT_BITS      = 32;
   localparam int COUNT_OUT_BITS = 5;
   localparam int WIDE_BITS     = 64;

   localparam int FIFO_DEPTH    = 2;
   localparam int FIFO_PTR_BITS = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   localparam logic [2:0] MODE_PUSH_BACK  = 3'd0;
   localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
   localparam logic [2:0] MODE_POP_BACK   = 3'd2;
   localparam logic [2:0] MODE_POP_FRONT  = 3'd3;
   localparam logic [2:0] MODE_DELETE     = 3'd4;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH_BACK,
      OP_PUSH_FRONT,
      OP_POP_BACK,
      OP_POP_FRONT,
      OP_DELETE
   } op_type;

   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      op_type    op;
      value_type value;
   } cmd_type;

endpackage

// File: sv/double_ended_queue_with_delete_core.sv
// top level of the bounded double-ended queue with delete by value
//
// each request carries a mode (push back, push front, pop back, pop front,
// delete value) and a value; every request gives exactly one response with
// the new front and back values, the entry count, a found flag and an error
// flag. push when full and pop when empty set error and leave the queue as is.
// requests are decoded and placed in a two-entry command queue; the execute
// stage takes one command per cycle while the response register is free or
// being taken, compares all entry cells at once and shifts them in the same
// cycle, so throughput is one request per cycle unless the receiver stalls;
// a request goes through the command queue and then the response register.
// reset empties the queue and drops any queued command or pending response;
// entry cells keep no reset value and are read only after being written.
// when the receiver stalls the response register holds, the execute stage
// waits and the command queue fills, after which req_ready falls.
module double_ended_queue_with_delete_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_front_value,
   output logic [31:0] rsp_back_value,
   output logic [4:0]  rsp_entry_count,
   output logic        rsp_found,
   output logic        rsp_error
);

   dqd_pkg::cmd_type dec_cmd, exe_cmd;
   logic             dec_valid, dec_ready, exe_valid, exe_ready;

   dqd_front u_front (
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .req_value (req_value),
      .cmd_valid (dec_valid),
      .cmd_ready (dec_ready),
      .cmd       (dec_cmd)
   );

   dqd_cmd_fifo u_cmd_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (dec_valid),
      .push_ready (dec_ready),
      .push_data  (dec_cmd),
      .pop_valid  (exe_valid),
      .pop_ready  (exe_ready),
      .pop_data   (exe_cmd)
   );

   dqd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (exe_valid),
      .cmd_ready       (exe_ready),
      .cmd             (exe_cmd),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_found       (rsp_found),
      .rsp_error       (rsp_error)
   );

endmodule

// File: sv/dqd_front.sv
// request decode: turns mode and value into a command for the queue
module dqd_front (
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_mode,
   input  logic [31:0]      req_value,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output dqd_pkg::cmd_type cmd
);

   logic [dqd_pkg::WIDE_BITS-1:0] value_wide;

   assign value_wide = dqd_pkg::WIDE_BITS'(req_value);
   assign cmd_valid  = req_valid;
   assign req_ready  = cmd_ready;

   always_comb begin
      cmd.value = value_wide[dqd_pkg::VALUE_BITS-1:0];
      case (req_mode)
         dqd_pkg::MODE_PUSH_BACK:  cmd.op = dqd_pkg::OP_PUSH_BACK;
         dqd_pkg::MODE_PUSH_FRONT: cmd.op = dqd_pkg::OP_PUSH_FRONT;
         dqd_pkg::MODE_POP_BACK:   cmd.op = dqd_pkg::OP_POP_BACK;
         dqd_pkg::MODE_POP_FRONT:  cmd.op = dqd_pkg::OP_POP_FRONT;
         dqd_pkg::MODE_DELETE:     cmd.op = dqd_pkg::OP_DELETE;
         default:                  cmd.op = dqd_pkg::OP_NOP;
      endcase
   end

endmodule

// File: sv/dqd_cmd_fifo.sv
// short command queue between decode and execute
module dqd_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  dqd_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output dqd_pkg::cmd_type pop_data
);

   dqd_pkg::cmd_type                   slots_ff [dqd_pkg::FIFO_DEPTH];
   logic [dqd_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [dqd_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [dqd_pkg::FIFO_CNT_BITS-1:0]  count_ff, count_in;
   logic                               do_push, do_pop;

   assign push_ready = count_ff != dqd_pkg::FIFO_CNT_BITS'(dqd_pkg::FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         if (wr_ptr_ff == dqd_pkg::FIFO_PTR_BITS'(dqd_pkg::FIFO_DEPTH - 1)) begin
            wr_ptr_in = '0;
         end else begin
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
      end
      if (do_pop) begin
         if (rd_ptr_ff == dqd_pkg::FIFO_PTR_BITS'(dqd_pkg::FIFO_DEPTH - 1)) begin
            rd_ptr_in = '0;
         end else begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: sv/dqd_back.sv
// execute stage: chain of entry cells, parallel compare, shift, result register
module dqd_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  dqd_pkg::cmd_type cmd,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [31:0]      rsp_front_value,
   output logic [31:0]      rsp_back_value,
   output logic [4:0]       rsp_entry_count,
   output logic             rsp_found,
   output logic             rsp_error
);

   dqd_pkg::value_type            cells_ff [dqd_pkg::DEPTH];
   dqd_pkg::value_type            cells_in [dqd_pkg::DEPTH];
   logic [dqd_pkg::CNT_BITS-1:0]  held_ff, held_in;
   logic [dqd_pkg::CNT_BITS-1:0]  front_pos;
   logic [dqd_pkg::DEPTH-1:0]     match, hit_below;
   logic                          exec, found, error;
   dqd_pkg::value_type            front_val, back_val;

   logic                          rsp_valid_ff;
   dqd_pkg::value_type            rsp_front_ff, rsp_back_ff;
   logic [dqd_pkg::CNT_BITS-1:0]  rsp_count_ff;
   logic                          rsp_found_ff, rsp_error_ff;

   logic [dqd_pkg::WIDE_BITS-1:0] front_wide, back_wide, count_wide;

   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign exec      = cmd_valid && cmd_ready;

   // compare every live entry at once, then mark the first hit from the back upward
   always_comb begin
      for (int i = 0; i < dqd_pkg::DEPTH; i++) begin
         match[i] = (dqd_pkg::CNT_BITS'(i) < held_ff) && (cells_ff[i] == cmd.value);
      end
      hit_below[0] = match[0];
      for (int i = 1; i < dqd_pkg::DEPTH; i++) begin
         hit_below[i] = hit_below[i-1] | match[i];
      end
   end

   always_comb begin
      cells_in = cells_ff;
      held_in  = held_ff;
      found    = 1'b0;
      error    = 1'b0;
      case (cmd.op)
         dqd_pkg::OP_PUSH_BACK: begin
            if (held_ff == dqd_pkg::CNT_BITS'(dqd_pkg::DEPTH)) begin
               error = 1'b1;
            end else begin
               for (int i = dqd_pkg::DEPTH - 1; i > 0; i--) begin
                  cells_in[i] = cells_ff[i-1];
               end
               cells_in[0] = cmd.value;
               held_in     = held_ff + 1'b1;
            end
         end
         dqd_pkg::OP_PUSH_FRONT: begin
            if (held_ff == dqd_pkg::CNT_BITS'(dqd_pkg::DEPTH)) begin
               error = 1'b1;
            end else begin
               cells_in[held_ff[dqd_pkg::IDX_BITS-1:0]] = cmd.value;
               held_in = held_ff + 1'b1;
            end
         end
         dqd_pkg::OP_POP_BACK: begin
            if (held_ff == '0) begin
               error = 1'b1;
            end else begin
               for (int i = 0; i < dqd_pkg::DEPTH - 1; i++) begin
                  cells_in[i] = cells_ff[i+1];
               end
               held_in = held_ff - 1'b1;
            end
         end
         dqd_pkg::OP_POP_FRONT: begin
            if (held_ff == '0) begin
               error = 1'b1;
            end else begin
               held_in = held_ff - 1'b1;
            end
         end
         dqd_pkg::OP_DELETE: begin
            if (|match) begin
               // close the gap: everything from the hit upward moves one place back
               for (int i = 0; i < dqd_pkg::DEPTH - 1; i++) begin
                  if (hit_below[i]) begin
                     cells_in[i] = cells_ff[i+1];
                  end
               end
               held_in = held_ff - 1'b1;
               found   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign front_pos = held_in - 1'b1;

   always_comb begin
      if (held_in == '0) begin
         front_val = '0;
         back_val  = '0;
      end else begin
         front_val = cells_in[front_pos[dqd_pkg::IDX_BITS-1:0]];
         back_val  = cells_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (exec) begin
            held_ff      <= held_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         cells_ff     <= cells_in;
         rsp_front_ff <= front_val;
         rsp_back_ff  <= back_val;
         rsp_count_ff <= held_in;
         rsp_found_ff <= found;
         rsp_error_ff <= error;
      end
   end

   assign front_wide      = dqd_pkg::WIDE_BITS'(rsp_front_ff);
   assign back_wide       = dqd_pkg::WIDE_BITS'(rsp_back_ff);
   assign count_wide      = dqd_pkg::WIDE_BITS'(rsp_count_ff);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_value = front_wide[dqd_pkg::OUT_BITS-1:0];
   assign rsp_back_value  = back_wide[dqd_pkg::OUT_BITS-1:0];
   assign rsp_entry_count = count_wide[dqd_pkg::COUNT_OUT_BITS-1:0];
   assign rsp_found       = rsp_found_ff;
   assign rsp_error       = rsp_error_ff;

endmodule

// File: verif/tb_top.sv
// self-checking testbench for the double-ended queue with delete by value
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // modes that the block treats as no operation
   localparam logic [2:0] MODE_SPARE_5 = 3'd5;
   localparam logic [2:0] MODE_SPARE_6 = 3'd6;
   localparam logic [2:0] MODE_SPARE_7 = 3'd7;

   localparam int RANDOM_REQUESTS = 516;
   localparam int HOLD_OFF_CYCLES = 64;
   localparam int DRAIN_CYCLES    = 10;
   localparam int STALL_LIMIT     = 5000;

   typedef struct packed {
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [4:0]  entry_count;
      logic        found;
      logic        error;
   } deque_view_type;

   typedef struct packed {
      logic [2:0]     mode;
      logic [31:0]    value;
      int             repeats;
      bit             typed;
      deque_view_type view;
   } drill_row_type;

   localparam deque_view_type NO_VIEW    = '{32'h0, 32'h0, 5'd0, 1'b0, 1'b0};
   localparam deque_view_type EMPTY_FAIL = '{32'h0, 32'h0, 5'd0, 1'b0, 1'b1};

   localparam int DRILL_ROWS = 21;
   localparam drill_row_type DRILL_TABLE [DRILL_ROWS] = '{
      '{dqd_pkg::MODE_POP_BACK,   32'h0000_0000, 1, 1'b1, EMPTY_FAIL},
      '{dqd_pkg::MODE_POP_FRONT,  32'hFFFF_FFFF, 1, 1'b1, EMPTY_FAIL},
      '{dqd_pkg::MODE_DELETE,     32'h0000_0000, 1, 1'b1, NO_VIEW},
      '{MODE_SPARE_5,             32'hFFFF_FFFF, 1, 1'b1, NO_VIEW},
      '{dqd_pkg::MODE_PUSH_BACK,  32'hFFFF_FFFF, 1, 1'b1,
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0}},
      '{dqd_pkg::MODE_DELETE,     32'hFFFF_FFFF, 1, 1'b1,
        '{32'h0, 32'h0, 5'd0, 1'b1, 1'b0}},
      '{dqd_pkg::MODE_PUSH_FRONT, 32'h0000_0000, 1, 1'b1,
        '{32'h0, 32'h0, 5'd1, 1'b0, 1'b0}},
      // fill up to full from both ends
      '{dqd_pkg::MODE_PUSH_BACK,  32'h0000_1000, 8, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_PUSH_FRONT, 32'h0000_2000, 7, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_PUSH_BACK,  32'h5555_5555, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_PUSH_FRONT, 32'hAAAA_AAAA, 1, 1'b0, NO_VIEW},
      '{MODE_SPARE_7,             32'h0000_0000, 1, 1'b0, NO_VIEW},
      // back entry, front entry, one in the middle, then a miss
      '{dqd_pkg::MODE_DELETE,     32'h0000_1007, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_DELETE,     32'h0000_2006, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_DELETE,     32'h0000_1003, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_DELETE,     32'hDEAD_BEEF, 1, 1'b0, NO_VIEW},
      '{MODE_SPARE_6,             32'h0000_1001, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_POP_BACK,   32'h0000_0000, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_POP_FRONT,  32'h0000_0000, 1, 1'b0, NO_VIEW},
      // duplicate at the back must be the one removed
      '{dqd_pkg::MODE_PUSH_BACK,  32'h0000_1001, 1, 1'b0, NO_VIEW},
      '{dqd_pkg::MODE_DELETE,     32'h0000_1001, 1, 1'b0, NO_VIEW}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = dqd_pkg::MODE_PUSH_BACK;
   logic [31:0] req_value = 32'h0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_front_value;
   logic [31:0] rsp_back_value;
   logic [4:0]  rsp_entry_count;
   logic        rsp_found;
   logic        rsp_error;

   dqd_pkg::value_type shadow_cells [dqd_pkg::DEPTH];
   int                 shadow_held = 0;
   deque_view_type     queue_snapshots [$];

   bit          steady_stretch = 1'b0;
   bit          hold_off_request = 1'b0;
   int          mismatch_count = 0;
   int          responses_checked = 0;
   int          error_responses = 0;
   int          delete_hits = 0;
   int          full_responses = 0;
   int          quiet_cycles = 0;

   double_ended_queue_with_delete_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_found       (rsp_found),
      .rsp_error       (rsp_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // position 0 is the back, shadow_held-1 the front
   function automatic deque_view_type apply_to_deque(input logic [2:0] mode,
                                                     input dqd_pkg::value_type value);
      deque_view_type view;
      int hit_pos;
      view = NO_VIEW;
      hit_pos = -1;
      case (mode)
         dqd_pkg::MODE_PUSH_BACK: begin
            if (shadow_held >= dqd_pkg::DEPTH) begin
               view.error = 1'b1;
            end else begin
               for (int i = shadow_held; i > 0; i--) shadow_cells[i] = shadow_cells[i-1];
               shadow_cells[0] = value;
               shadow_held++;
            end
         end
         dqd_pkg::MODE_PUSH_FRONT: begin
            if (shadow_held >= dqd_pkg::DEPTH) begin
               view.error = 1'b1;
            end else begin
               shadow_cells[shadow_held] = value;
               shadow_held++;
            end
         end
         dqd_pkg::MODE_POP_BACK: begin
            if (shadow_held == 0) begin
               view.error = 1'b1;
            end else begin
               for (int i = 0; i + 1 < shadow_held; i++) shadow_cells[i] = shadow_cells[i+1];
               shadow_held--;
            end
         end
         dqd_pkg::MODE_POP_FRONT: begin
            if (shadow_held == 0) view.error = 1'b1;
            else shadow_held--;
         end
         dqd_pkg::MODE_DELETE: begin
            for (int i = 0; i < shadow_held; i++) begin
               if (hit_pos < 0 && shadow_cells[i] == value) hit_pos = i;
            end
            if (hit_pos >= 0) begin
               for (int i = hit_pos; i + 1 < shadow_held; i++) begin
                  shadow_cells[i] = shadow_cells[i+1];
               end
               shadow_held--;
               view.found = 1'b1;
            end
         end
         default: ;
      endcase
      if (shadow_held != 0) begin
         view.front_value = shadow_cells[shadow_held-1];
         view.back_value  = shadow_cells[0];
      end
      view.entry_count = shadow_held[4:0];
      return view;
   endfunction

   task automatic offer_request(input logic [2:0] mode, input logic [31:0] value,
                                input bit typed, input deque_view_type typed_view);
      deque_view_type predicted;
      if (!steady_stretch && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode  <= mode;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_to_deque(mode, value);
      queue_snapshots.push_back(typed ? typed_view : predicted);
   endtask

   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return $urandom_range(7);
      if (roll < 40) return ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
      return $urandom;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: random back-pressure, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= steady_stretch || ($urandom_range(99) >= 33);
         end
      end
   end

   always @(posedge clock) begin
      deque_view_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (queue_snapshots.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = queue_snapshots.pop_front();
            check_field("front_value", want.front_value, rsp_front_value);
            check_field("back_value", want.back_value, rsp_back_value);
            check_field("entry_count", want.entry_count, rsp_entry_count);
            check_field("found", want.found, rsp_found);
            check_field("error", want.error, rsp_error);
         end
         responses_checked++;
         if (rsp_error) error_responses++;
         if (rsp_found) delete_hits++;
         if (rsp_entry_count == dqd_pkg::DEPTH) full_responses++;
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no handshake for %0d cycles, %0d responses outstanding",
                  STALL_LIMIT, queue_snapshots.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int random_sent;
      int draws;
      int phase_left;
      int push_pct;
      int pop_pct;
      int roll;
      logic [2:0] mode;
      logic [31:0] value;
      random_sent = 0;
      draws = 0;
      phase_left = 0;
      push_pct = 40;
      pop_pct = 35;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DRILL_TABLE[r]) begin
         for (int k = 0; k < DRILL_TABLE[r].repeats; k++) begin
            offer_request(DRILL_TABLE[r].mode, DRILL_TABLE[r].value + k,
                          DRILL_TABLE[r].typed, DRILL_TABLE[r].view);
         end
      end

      while (random_sent < RANDOM_REQUESTS) begin
         if (phase_left == 0) begin
            // grow, shrink or churn so that full and empty are both reached
            phase_left = $urandom_range(40, 15);
            case ($urandom_range(2))
               0: begin push_pct = 70; pop_pct = 15; end
               1: begin push_pct = 15; pop_pct = 65; end
               default: begin push_pct = 40; pop_pct = 35; end
            endcase
         end
         phase_left--;
         steady_stretch = (random_sent >= 250 && random_sent < 350);
         if (draws == 120 || draws == 450) hold_off_request = 1'b1;
         draws++;

         roll = $urandom_range(99);
         value = pick_value();
         if (roll < 4) begin
            case ($urandom_range(2))
               0: mode = MODE_SPARE_5;
               1: mode = MODE_SPARE_6;
               default: mode = MODE_SPARE_7;
            endcase
         end else begin
            roll = $urandom_range(99);
            if (roll < push_pct) begin
               mode = ($urandom_range(1) != 0) ? dqd_pkg::MODE_PUSH_BACK
                                               : dqd_pkg::MODE_PUSH_FRONT;
            end else if (roll < push_pct + pop_pct) begin
               mode = ($urandom_range(1) != 0) ? dqd_pkg::MODE_POP_BACK
                                               : dqd_pkg::MODE_POP_FRONT;
            end else begin
               mode = dqd_pkg::MODE_DELETE;
               // mostly aim at a value that is held, so deletes hit
               if (shadow_held > 0 && $urandom_range(99) < 65) begin
                  value = shadow_cells[$urandom_range(shadow_held - 1)];
               end
            end
         end
         random_sent++;
         offer_request(mode, value, 1'b0, NO_VIEW);
      end
      req_valid <= 1'b0;
      steady_stretch = 1'b0;

      while (queue_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d responses: %0d flagged errors, %0d delete hits, %0d at full",
               responses_checked, error_responses, delete_hits, full_responses);
      $display("%0d field mismatches", mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
